// File: src/sfcr_pkg.sv
// Shared types, constants and the CRC byte update for the stuffed frame receiver.
package sfcr_pkg;

  // Line codes and CRC constants.
  localparam logic [7:0]  MarkByte = 8'hAA;
  localparam logic [7:0]  FillByte = 8'h55;
  localparam logic [31:0] CrcPoly  = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit  = 32'hFFFF_FFFF;

  // Payload store geometry and field widths.
  localparam int StoreDepth = 64;
  localparam int IdxW       = 6;
  localparam int LenW       = 7;
  localparam int IdW        = 6;
  localparam int MaxFramePayloadDefault = 64;

  // Receiver phases plus the two replay states.
  typedef enum logic [3:0] {
    PH_SEARCH,
    PH_ID,
    PH_LEN,
    PH_DATA,
    PH_CRC3,
    PH_CRC2,
    PH_CRC1,
    PH_CRC0,
    PH_END,
    PH_RD,
    PH_EMIT
  } phase_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic id_load;
    logic len_load;
    logic data_write;
    logic crc_init;
    logic crc_feed;
    logic rx_shift;
    logic rep_clear;
    logic rep_read;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_mark;
    logic is_fill;
    logic len_zero;
    logic len_ok;
    logic last_data;
    logic crc_ok;
    logic frame_empty;
    logic rep_last;
    logic out_free;
  } dp_status_t;

  // Reflected CRC-32 update over one byte.
  function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: src/sfcr_ctrl.sv
// Controller state machine: frame phases, header run tracking and replay sequencing.
module sfcr_ctrl import sfcr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  phase_e     state_q, state_d;
  logic [1:0] hr_q, hr_d;
  logic       replaying;
  logic       accept;
  logic       data_byte;

  // Input is held off only while a frame is replayed.
  assign replaying  = (state_q == PH_RD) || (state_q == PH_EMIT);
  assign in_stall_o = replaying;
  assign accept     = in_valid_i && !replaying;
  // A byte after two marks is a stuff check and issues no datapath command.
  assign data_byte  = accept && (hr_q != 2'd2);

  // Next state and header run.
  always_comb begin
    state_d = state_q;
    hr_d    = hr_q;
    if (state_q == PH_RD) begin
      state_d = PH_EMIT;
    end else if (state_q == PH_EMIT) begin
      if (status_i.out_free && status_i.rep_last) begin
        state_d = PH_SEARCH;
      end else if (status_i.out_free) begin
        state_d = PH_RD;
      end
    end else if (accept && hr_q == 2'd2) begin
      hr_d = 2'd0;
      if (status_i.is_mark) begin
        state_d = PH_ID;
      end else if (!status_i.is_fill) begin
        state_d = PH_SEARCH;
      end
    end else if (accept) begin
      hr_d = status_i.is_mark ? hr_q + 2'd1 : 2'd0;
      case (state_q)
        PH_SEARCH: state_d = PH_SEARCH;
        PH_ID:     state_d = PH_LEN;
        PH_LEN: begin
          if (status_i.len_zero) begin
            state_d = PH_CRC3;
          end else if (status_i.len_ok) begin
            state_d = PH_DATA;
          end else begin
            state_d = PH_SEARCH;
          end
        end
        PH_DATA: begin
          if (status_i.last_data) begin
            state_d = PH_CRC3;
          end
        end
        PH_CRC3: state_d = PH_CRC2;
        PH_CRC2: state_d = PH_CRC1;
        PH_CRC1: state_d = PH_CRC0;
        PH_CRC0: state_d = status_i.crc_ok ? PH_END : PH_SEARCH;
        PH_END: begin
          if (!status_i.is_fill) begin
            state_d = PH_SEARCH;
          end else if (status_i.frame_empty) begin
            state_d = PH_EMIT;
          end else begin
            state_d = PH_RD;
          end
        end
        default: state_d = PH_SEARCH;
      endcase
    end
  end

  // Datapath commands.
  always_comb begin
    cmd_o            = '0;
    cmd_o.id_load    = data_byte && (state_q == PH_ID);
    cmd_o.len_load   = data_byte && (state_q == PH_LEN);
    cmd_o.data_write = data_byte && (state_q == PH_DATA);
    cmd_o.crc_init   = data_byte && (state_q == PH_ID);
    cmd_o.crc_feed   = data_byte && ((state_q == PH_ID) || (state_q == PH_LEN) ||
                                     (state_q == PH_DATA));
    cmd_o.rx_shift   = data_byte && ((state_q == PH_CRC3) || (state_q == PH_CRC2) ||
                                     (state_q == PH_CRC1) || (state_q == PH_CRC0));
    cmd_o.rep_clear  = data_byte && (state_q == PH_END) && status_i.is_fill;
    cmd_o.rep_read   = (state_q == PH_RD);
    cmd_o.emit       = (state_q == PH_EMIT) && status_i.out_free;
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PH_SEARCH;
      hr_q    <= 2'd0;
    end else begin
      state_q <= state_d;
      hr_q    <= hr_d;
    end
  end

endmodule

// File: src/sfcr_datapath.sv
// Datapath: CRC accumulator, frame header registers, payload store and output register.
module sfcr_datapath import sfcr_pkg::*; #(
  parameter int MaxFramePayload = MaxFramePayloadDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       line_byte_i,
  input  ctrl_cmd_t        cmd_i,
  output dp_status_t       status_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [IdW-1:0]   frame_id_o,
  output logic [LenW-1:0]  payload_length_o,
  output logic [IdxW-1:0]  byte_index_o,
  output logic [7:0]       data_value_o,
  output logic             has_data_o,
  output logic             last_o
);

  logic [31:0]     crc_q;
  logic [31:0]     rx_q;
  logic [IdW-1:0]  id_q;
  logic [LenW-1:0] remaining_q;
  logic [LenW-1:0] frame_len_q;
  logic [IdxW-1:0] wr_idx_q;
  logic [IdxW-1:0] rep_idx_q;
  logic [7:0]      rd_data_q;
  logic [7:0]      store_q [StoreDepth];

  logic            out_valid_q;
  logic [IdW-1:0]  out_id_q;
  logic [LenW-1:0] out_len_q;
  logic [IdxW-1:0] out_idx_q;
  logic [7:0]      out_data_q;
  logic            out_has_q;
  logic            out_last_q;

  logic [31:0]     crc_base;

  // Status toward the controller.
  assign status_o.is_mark     = (line_byte_i == MarkByte);
  assign status_o.is_fill     = (line_byte_i == FillByte);
  assign status_o.len_zero    = (line_byte_i == 8'h00);
  assign status_o.len_ok      = (line_byte_i <= 8'(MaxFramePayload));
  assign status_o.last_data   = (remaining_q == LenW'(1));
  assign status_o.crc_ok      = ({rx_q[23:0], line_byte_i} == ~crc_q);
  assign status_o.frame_empty = (frame_len_q == '0);
  assign status_o.rep_last    = (frame_len_q == '0) ||
                                (({1'b0, rep_idx_q} + LenW'(1)) == frame_len_q);
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

  assign crc_base = cmd_i.crc_init ? CrcInit : crc_q;

  // Frame header, CRC and index registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.crc_feed) begin
      crc_q <= crc_feed(crc_base, line_byte_i);
    end
    if (cmd_i.rx_shift) begin
      rx_q <= {rx_q[23:0], line_byte_i};
    end
    if (cmd_i.id_load) begin
      id_q     <= line_byte_i[IdW-1:0];
      wr_idx_q <= '0;
    end
    if (cmd_i.len_load) begin
      remaining_q <= line_byte_i[LenW-1:0];
      frame_len_q <= line_byte_i[LenW-1:0];
    end
    if (cmd_i.data_write) begin
      wr_idx_q    <= wr_idx_q + IdxW'(1);
      remaining_q <= remaining_q - LenW'(1);
    end
    if (cmd_i.rep_clear) begin
      rep_idx_q <= '0;
    end else if (cmd_i.emit) begin
      rep_idx_q <= rep_idx_q + IdxW'(1);
    end
  end

  // Payload store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.data_write) begin
      store_q[wr_idx_q] <= line_byte_i;
    end
    if (cmd_i.rep_read) begin
      rd_data_q <= store_q[rep_idx_q];
    end
  end

  // Output item register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_id_q   <= id_q;
      out_len_q  <= frame_len_q;
      out_idx_q  <= rep_idx_q;
      out_data_q <= status_o.frame_empty ? 8'h00 : rd_data_q;
      out_has_q  <= !status_o.frame_empty;
      out_last_q <= status_o.rep_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_id_o       = out_id_q;
  assign payload_length_o = out_len_q;
  assign byte_index_o     = out_idx_q;
  assign data_value_o     = out_data_q;
  assign has_data_o       = out_has_q;
  assign last_o           = out_last_q;

endmodule

// File: src/stuffed_frame_crc32_receiver.sv
// Top level of the byte-stuffed frame receiver with CRC-32 check.
//
//  Channel  Direction  Handshake               Payload
//  in       input      in_valid_i/in_stall_o   line_byte_i
//  out      output     out_valid_o/out_stall_i frame_id_o, payload_length_o, byte_index_o,
//                                              data_value_o, has_data_o, last_o
//
// A line byte is taken in one cycle while a frame is being received.
// A good end byte starts a replay in which each result takes a store read, then an output
// register load; input is held off for the whole replay, and an empty frame skips the
// store read. Output stalls lengthen the replay.
// Reset (asynchronous, active low) returns to searching for a start of frame.
module stuffed_frame_crc32_receiver import sfcr_pkg::*; #(
  parameter int MaxFramePayload = MaxFramePayloadDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      line_byte_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [IdW-1:0]  frame_id_o,
  output logic [LenW-1:0] payload_length_o,
  output logic [IdxW-1:0] byte_index_o,
  output logic [7:0]      data_value_o,
  output logic            has_data_o,
  output logic            last_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Frame phase controller.
  sfcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath with payload store and output register.
  sfcr_datapath #(
    .MaxFramePayload (MaxFramePayload)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .line_byte_i      (line_byte_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .frame_id_o       (frame_id_o),
    .payload_length_o (payload_length_o),
    .byte_index_o     (byte_index_o),
    .data_value_o     (data_value_o),
    .has_data_o       (has_data_o),
    .last_o           (last_o)
  );

endmodule

// File: test/stuffed_frame_crc32_receiver_tb.sv
// Self-checking testbench for the byte-stuffed frame receiver with CRC-32 check.
`timescale 1ns / 100ps

module stuffed_frame_crc32_receiver_tb;
  import sfcr_pkg::*;

  localparam int MaxPayload    = MaxFramePayloadDefault;
  localparam int HoldCycles    = 400;
  localparam int WatchdogLimit = 2000;
  localparam int TailCycles    = 300;

  // Ways a generated frame can be spoiled on the line.
  typedef enum {FR_GOOD, FR_BAD_CRC, FR_BAD_END, FR_OVERSIZE, FR_BAD_STUFF, FR_CUT} frame_fault_e;

  // One line item, or a marker that holds the sender until all results are in.
  typedef struct {
    bit         drain;
    logic [7:0] value;
  } line_item_t;

  // One replayed payload result as the block should present it.
  typedef struct {
    logic [IdW-1:0]  id;
    logic [LenW-1:0] len;
    logic [IdxW-1:0] idx;
    logic [7:0]      value;
    logic            has_data;
    logic            last;
  } frame_result_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic [7:0]      line_byte_i = 8'h00;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [IdW-1:0]  frame_id_o;
  logic [LenW-1:0] payload_length_o;
  logic [IdxW-1:0] byte_index_o;
  logic [7:0]      data_value_o;
  logic            has_data_o;
  logic            last_o;

  line_item_t    line_queue[$];
  frame_result_t frame_results[$];
  int unsigned   line_bytes_queued = 0;
  int unsigned   bound_a = 0;
  int unsigned   bound_b = 0;
  int unsigned   items_sent = 0;
  int unsigned   hold_left = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   mismatches = 0;
  bit            hold_done = 1'b0;
  bit            draining = 1'b0;
  bit            stim_done = 1'b0;
  bit            results_drained = 1'b1;

  // Receiver state mirrored by the predictor.
  phase_e          rx_phase = PH_SEARCH;
  logic [1:0]      mark_run = '0;
  logic [31:0]     crc_acc = '0;
  logic [31:0]     crc_rx = '0;
  logic [7:0]      id_latch = '0;
  logic [6:0]      remaining = '0;
  logic [6:0]      frame_len = '0;
  logic [IdxW-1:0] wr_idx = '0;
  logic [7:0]      payload_mem [StoreDepth];

  stuffed_frame_crc32_receiver #(.MaxFramePayload(MaxPayload)) dut (.*);

  // Clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Reflected CRC-32, one bit of the byte at a time, LSB first.
  function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = {1'b0, c[31:1]} ^ (fb ? CrcPoly : 32'h0);
    end
    return c;
  endfunction

  // Traffic profile: sender fast then slow, receiver the other way, then full rate.
  function automatic int unsigned sender_idle_pct(input int unsigned sent);
    return (sent < bound_a) ? 28 : (sent < bound_b) ? 82 : 0;
  endfunction

  function automatic int unsigned receiver_stall_pct(input int unsigned sent);
    return (sent < bound_a) ? 82 : (sent < bound_b) ? 28 : 0;
  endfunction

  // Advance the receiver model by one accepted line byte and queue any replay.
  task automatic predict_line_byte(input logic [7:0] b);
    frame_result_t r;
    // The byte after two marks is a stuff check, not frame content.
    if (mark_run == 2'd2) begin
      mark_run = 2'd0;
      if (b == MarkByte) rx_phase = PH_ID;
      else if (b != FillByte) rx_phase = PH_SEARCH;
      return;
    end
    mark_run = (b == MarkByte) ? mark_run + 2'd1 : 2'd0;
    case (rx_phase)
      PH_ID: begin
        id_latch = b;
        wr_idx = '0;
        crc_acc = crc32_update(CrcInit, b);
        rx_phase = PH_LEN;
      end
      PH_LEN: begin
        remaining = b[6:0];
        frame_len = b[6:0];
        crc_acc = crc32_update(crc_acc, b);
        if (b == 8'h00) rx_phase = PH_CRC3;
        else if (b <= MaxPayload) rx_phase = PH_DATA;
        else rx_phase = PH_SEARCH;
      end
      PH_DATA: begin
        payload_mem[wr_idx] = b;
        wr_idx = wr_idx + 1'b1;
        crc_acc = crc32_update(crc_acc, b);
        remaining = remaining - 1'b1;
        if (remaining == '0) rx_phase = PH_CRC3;
      end
      PH_CRC3: begin
        crc_rx = {b, 24'h0};
        rx_phase = PH_CRC2;
      end
      PH_CRC2: begin
        crc_rx[23:16] = b;
        rx_phase = PH_CRC1;
      end
      PH_CRC1: begin
        crc_rx[15:8] = b;
        rx_phase = PH_CRC0;
      end
      PH_CRC0: begin
        crc_rx[7:0] = b;
        rx_phase = (crc_rx == ~crc_acc) ? PH_END : PH_SEARCH;
      end
      PH_END: begin
        rx_phase = PH_SEARCH;
        if (b == FillByte) begin
          r.id = id_latch[IdW-1:0];
          r.len = frame_len;
          if (frame_len == '0) begin
            // An empty frame still reports once, without data.
            r.idx = '0;
            r.value = 8'h00;
            r.has_data = 1'b0;
            r.last = 1'b1;
            frame_results.push_back(r);
          end else begin
            for (int k = 0; k < frame_len; k++) begin
              r.idx = k[IdxW-1:0];
              r.value = payload_mem[k];
              r.has_data = 1'b1;
              r.last = (k + 1 == frame_len);
              frame_results.push_back(r);
            end
          end
        end
      end
      default: rx_phase = PH_SEARCH;
    endcase
  endtask

  // Stimulus building.
  task automatic push_byte(input logic [7:0] b);
    line_queue.push_back('{drain: 1'b0, value: b});
    line_bytes_queued++;
  endtask

  task automatic add_drain_point();
    line_queue.push_back('{drain: 1'b1, value: 8'h00});
  endtask

  // Frame content byte, with a stuff byte inserted after every pair of marks.
  task automatic push_stuffed(input logic [7:0] b, inout int run);
    push_byte(b);
    run = (b == MarkByte) ? run + 1 : 0;
    if (run == 2) begin
      push_byte(FillByte);
      run = 0;
    end
  endtask

  function automatic logic [7:0] rand_payload();
    return ($urandom_range(0, 3) == 0) ? MarkByte : 8'($urandom_range(0, 255));
  endfunction

  // Put one frame on the line, spoiled as the fault asks.
  // For an oversize frame, len is the raw length byte.
  task automatic send_frame(input logic [7:0] id, input int unsigned len,
                            input frame_fault_e fault);
    logic [7:0]  body[$];
    logic [31:0] crc;
    logic [7:0]  junk;
    int          run;
    int unsigned stop_at;
    crc = CrcInit;
    run = 0;
    body.push_back(id);
    body.push_back(len[7:0]);
    if (fault != FR_OVERSIZE) begin
      for (int k = 0; k < len; k++) body.push_back(rand_payload());
    end
    foreach (body[k]) crc = crc32_update(crc, body[k]);
    crc = ~crc;
    if (fault == FR_BAD_CRC) crc = crc ^ (32'h1 << $urandom_range(0, 31));
    body.push_back(crc[31:24]);
    body.push_back(crc[23:16]);
    body.push_back(crc[15:8]);
    body.push_back(crc[7:0]);
    case (fault)
      FR_OVERSIZE:  stop_at = 2;
      FR_CUT:       stop_at = $urandom_range(1, body.size() - 1);
      FR_BAD_STUFF: stop_at = $urandom_range(0, body.size() - 1);
      default:      stop_at = body.size();
    endcase
    repeat (3) push_byte(MarkByte);
    for (int k = 0; k < stop_at; k++) push_stuffed(body[k], run);
    case (fault)
      FR_GOOD, FR_BAD_CRC: push_byte(FillByte);
      FR_BAD_END: begin
        do junk = 8'($urandom_range(0, 255)); while (junk == FillByte);
        push_byte(junk);
      end
      FR_BAD_STUFF: begin
        // Two marks followed by something other than a stuff byte.
        do junk = 8'($urandom_range(0, 255)); while (junk == FillByte || junk == MarkByte);
        if (run == 0) push_byte(MarkByte);
        push_byte(MarkByte);
        push_byte(junk);
      end
      default: ;
    endcase
  endtask

  // Mostly well-formed frames with random content, plus broken frames and noise.
  task automatic add_random_traffic(input int unsigned byte_goal);
    int unsigned stop_count;
    int unsigned pick;
    int unsigned len;
    logic [7:0]  id;
    stop_count = line_bytes_queued + byte_goal;
    while (line_bytes_queued < stop_count) begin
      pick = $urandom_range(0, 99);
      id = 8'($urandom_range(0, 255));
      len = $urandom_range(0, 99);
      len = (len < 85) ? $urandom_range(0, 8) :
            (len < 97) ? $urandom_range(9, 32) : $urandom_range(33, MaxPayload);
      if (pick < 68) send_frame(id, len, FR_GOOD);
      else if (pick < 75) send_frame(id, len, FR_BAD_CRC);
      else if (pick < 81) send_frame(id, len, FR_BAD_END);
      else if (pick < 86) send_frame(id, $urandom_range(MaxPayload + 1, 255), FR_OVERSIZE);
      else if (pick < 91) send_frame(id, len, FR_BAD_STUFF);
      else if (pick < 95) send_frame(id, len, FR_CUT);
      else begin
        repeat ($urandom_range(1, 6)) begin
          push_byte(($urandom_range(0, 2) == 0) ? MarkByte : 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // Reports one field mismatch; returns 1 when the field matches.
  function automatic bit field_ok(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Sender: offers queued line items, holding at drain markers.
  always @(posedge clk_i) begin
    logic        take;
    logic        drive_next;
    line_item_t  item;
    int unsigned sent;
    if (rst_ni) begin
      take = in_valid_i && !in_stall_o;
      sent = items_sent + (take ? 1 : 0);
      items_sent <= sent;
      if (!in_valid_i || take) begin
        drive_next = 1'b0;
        // The drained flag is only trusted from the cycle after the marker.
        if (draining) begin
          if (results_drained) draining = 1'b0;
        end else if (line_queue.size() > 0 && line_queue[0].drain) begin
          void'(line_queue.pop_front());
          draining = 1'b1;
        end
        if (!draining && line_queue.size() > 0 &&
            $urandom_range(0, 99) >= sender_idle_pct(sent)) begin
          item = line_queue.pop_front();
          drive_next = 1'b1;
          line_byte_i <= item.value;
        end
        in_valid_i <= drive_next;
        stim_done <= !drive_next && !draining && line_queue.size() == 0;
      end
    end
  end

  // Result side stall, with one long hold-off early in the full-rate phase.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (!hold_done && items_sent > bound_b) begin
        hold_done <= 1'b1;
        hold_left <= HoldCycles;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < receiver_stall_pct(items_sent));
      end
    end
  end

  // Predict on accepted line bytes, check each accepted result against the oldest one.
  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_line_byte(line_byte_i);
      if (out_valid_o && !out_stall_i) begin
        if (frame_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual id=%0h len=%0h idx=%0h",
                   $time, frame_id_o, payload_length_o, byte_index_o);
        end else begin
          want = frame_results.pop_front();
          if (!(field_ok("frame_id", 32'(want.id), 32'(frame_id_o)) &
                field_ok("payload_length", 32'(want.len), 32'(payload_length_o)) &
                field_ok("byte_index", 32'(want.idx), 32'(byte_index_o)) &
                field_ok("data_value", 32'(want.value), 32'(data_value_o)) &
                field_ok("has_data", 32'(want.has_data), 32'(has_data_o)) &
                field_ok("last", 32'(want.last), 32'(last_o)))) begin
            mismatches++;
          end
        end
      end
      results_drained <= (frame_results.size() == 0);
    end
  end

  // Watchdog on cycles with no item moving on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("%0t: no progress for %0d cycles", $time, WatchdogLimit);
        $display("[stuffed_frame_crc32_receiver] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Build the stimulus, release reset, wait for the end and report.
  initial begin
    // Directed: empty frame with all ID bits set, one-byte frame, length just too big.
    send_frame(8'hFF, 0, FR_GOOD);
    send_frame(8'h00, 1, FR_GOOD);
    send_frame(8'h3F, MaxPayload + 1, FR_OVERSIZE);
    add_drain_point();
    add_random_traffic(90);
    bound_a = line_bytes_queued;
    add_drain_point();
    add_random_traffic(90);
    bound_b = line_bytes_queued;
    add_drain_point();
    // Full-size frames first so the long hold-off backs the block up.
    send_frame(8'($urandom_range(0, 255)), MaxPayload, FR_GOOD);
    send_frame(8'($urandom_range(0, 255)), MaxPayload, FR_GOOD);
    add_random_traffic(20);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (!(stim_done && results_drained));
    repeat (TailCycles) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0) begin
      $display("[stuffed_frame_crc32_receiver] OK");
    end else begin
      $display("[stuffed_frame_crc32_receiver] ERROR");
    end
    $finish;
  end

endmodule

// File: stuffed_frame_crc32_receiver.f
src/sfcr_pkg.sv
src/sfcr_ctrl.sv
src/sfcr_datapath.sv
src/stuffed_frame_crc32_receiver.sv
test/stuffed_frame_crc32_receiver_tb.sv
